/* hw/rtl/tsgp_pkg.sv */
// ----------------------------------------------------------------------------
// tsgp_pkg
// Shared sizes, token codes, control structs and helpers of the table grid
// placer.
// ----------------------------------------------------------------------------
package tsgp_pkg;

  // Sizing of the grid.
  localparam int MAX_COLS  = 256;
  localparam int MAX_SPAN  = 64;
  localparam int MAX_ROWS  = 1024;
  localparam int MAX_CELLS = 1024;

  // Fixed field widths of the token and placement words.
  localparam int OP_W         = 3;
  localparam int SPAN_VALUE_W = 12;
  localparam int CFG_W        = 11;
  localparam int SLOT_OUT_W   = 10;
  localparam int ROW_OUT_W    = 10;
  localparam int COL_OUT_W    = 8;
  localparam int SPAN_OUT_W   = 7;

  // Internal widths derived from the sizing.
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CUR_W  = $clog2(MAX_COLS + 1);
  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int FREE_W = $clog2(MAX_ROWS + MAX_SPAN);
  localparam int SLOT_W = $clog2(MAX_CELLS + 1);
  localparam int CMP_W  = (SLOT_W > CFG_W) ? SLOT_W : CFG_W;
  localparam int SUM_W  = ((CUR_W > SPAN_W) ? CUR_W : SPAN_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_START_TABLE = 3'd0,
    OP_ROW_START   = 3'd1,
    OP_EMPTY_CELL  = 3'd2,
    OP_OPEN_CELL   = 3'd3,
    OP_COLSPAN     = 3'd4,
    OP_ROWSPAN     = 3'd5,
    OP_CLOSE_TAG   = 3'd6,
    OP_OTHER       = 3'd7
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic row_start;
    logic take_slot;
    logic open_cell;
    logic set_cols;
    logic set_rows;
    logic close_cell;
    logic place_empty;
    logic place_open;
    logic scan;
    logic write;
    logic load_out;
  } tsgp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_seen;
    logic cell_open;
    logic empty_ok;
    logic close_ok;
    logic scan_found;
    logic scan_over;
    logic write_last;
  } tsgp_sts_t;

  // Clamps a parsed span attribute into 1..MAX_SPAN.
  function automatic logic [SPAN_W-1:0] clamp_span(input logic [SPAN_VALUE_W-1:0] v);
    logic [SPAN_W-1:0] r;
    if (v == '0) begin
      r = SPAN_W'(1);
    end else if (v > SPAN_VALUE_W'(MAX_SPAN)) begin
      r = SPAN_W'(MAX_SPAN);
    end else begin
      r = SPAN_W'(v);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/tsgp_if.sv */
// ----------------------------------------------------------------------------
// tsgp_if
// Valid/ready channels for table tokens and for cell placements.
// ----------------------------------------------------------------------------
interface tsgp_token_if;
  logic                              valid;
  logic                              ready;
  logic [tsgp_pkg::OP_W-1:0]         op;
  logic [tsgp_pkg::SPAN_VALUE_W-1:0] span_value;

  modport source (output valid, output op, output span_value, input ready);
  modport sink   (input valid, input op, input span_value, output ready);
endinterface

interface tsgp_place_if;
  logic                            valid;
  logic                            ready;
  logic [tsgp_pkg::SLOT_OUT_W-1:0] slot;
  logic [tsgp_pkg::ROW_OUT_W-1:0]  row;
  logic [tsgp_pkg::COL_OUT_W-1:0]  col;
  logic [tsgp_pkg::SPAN_OUT_W-1:0] rows_spanned;
  logic [tsgp_pkg::SPAN_OUT_W-1:0] cols_spanned;
  logic                            status;

  modport source (output valid, output slot, output row, output col, output rows_spanned,
                  output cols_spanned, output status, input ready);
  modport sink   (input valid, input slot, input row, input col, input rows_spanned,
                  input cols_spanned, input status, output ready);
endinterface

/* hw/rtl/tsgp_ram.sv */
// ----------------------------------------------------------------------------
// tsgp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tsgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tsgp_ctrl.sv */
// ----------------------------------------------------------------------------
// tsgp_ctrl
// Token decoder and placement sequencer of the table grid placer.
// ----------------------------------------------------------------------------
module tsgp_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      token_valid,
  input  logic [tsgp_pkg::OP_W-1:0] op,
  output logic                      token_ready,
  input  logic                      out_ready,
  output logic                      out_valid,
  input  tsgp_pkg::tsgp_sts_t       sts,
  output tsgp_pkg::tsgp_cmd_t       cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    WRITE,
    LOAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign token_ready = (state == IDLE);
  assign accept      = token_valid && token_ready;
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (accept) begin
          case (tsgp_pkg::op_t'(op))
            tsgp_pkg::OP_START_TABLE: cmd.clear = 1'b1;
            tsgp_pkg::OP_ROW_START:   cmd.row_start = 1'b1;
            tsgp_pkg::OP_EMPTY_CELL: begin
              cmd.take_slot = 1'b1;
              if (sts.empty_ok) begin
                cmd.place_empty = 1'b1;
                state_next      = SCAN;
              end
            end
            tsgp_pkg::OP_OPEN_CELL: begin
              cmd.take_slot = 1'b1;
              cmd.open_cell = 1'b1;
            end
            tsgp_pkg::OP_COLSPAN: cmd.set_cols = sts.cell_open;
            tsgp_pkg::OP_ROWSPAN: cmd.set_rows = sts.cell_open;
            tsgp_pkg::OP_CLOSE_TAG: begin
              if (sts.cell_open) begin
                cmd.close_cell = 1'b1;
                if (sts.close_ok) begin
                  cmd.place_open = 1'b1;
                  state_next     = SCAN;
                end
              end
            end
            default: ;
          endcase
        end
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_found) begin
          state_next = WRITE;
        end else if (sts.scan_over) begin
          state_next = LOAD;
        end
      end
      WRITE: begin
        cmd.write = 1'b1;
        if (sts.write_last) begin
          state_next = LOAD;
        end
      end
      LOAD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/tsgp_dp.sv */
// ----------------------------------------------------------------------------
// tsgp_dp
// Grid state, column store, run scanner and placement register of the table
// grid placer.
// ----------------------------------------------------------------------------
module tsgp_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tsgp_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [tsgp_pkg::SPAN_VALUE_W-1:0] span_value,
  input  tsgp_pkg::tsgp_cmd_t               cmd,
  output tsgp_pkg::tsgp_sts_t               sts,
  output logic [tsgp_pkg::SLOT_OUT_W-1:0]   o_slot,
  output logic [tsgp_pkg::ROW_OUT_W-1:0]    o_row,
  output logic [tsgp_pkg::COL_OUT_W-1:0]    o_col,
  output logic [tsgp_pkg::SPAN_OUT_W-1:0]   o_rows,
  output logic [tsgp_pkg::SPAN_OUT_W-1:0]   o_cols,
  output logic                              o_status
);

  localparam int COL_W  = tsgp_pkg::COL_W;
  localparam int CUR_W  = tsgp_pkg::CUR_W;
  localparam int SPAN_W = tsgp_pkg::SPAN_W;
  localparam int ROW_W  = tsgp_pkg::ROW_W;
  localparam int FREE_W = tsgp_pkg::FREE_W;
  localparam int SLOT_W = tsgp_pkg::SLOT_W;
  localparam int CMP_W  = tsgp_pkg::CMP_W;
  localparam int SUM_W  = tsgp_pkg::SUM_W;

  // Table state.
  logic [tsgp_pkg::CFG_W-1:0] cell_count;
  logic [ROW_W-1:0]           current_row;
  logic                       row_seen;
  logic [CUR_W-1:0]           cursor;
  logic [SLOT_W-1:0]          slot_ctr;
  logic                       cell_open;
  logic [SLOT_W-1:0]          cell_slot;
  logic [SPAN_W-1:0]          open_rows;
  logic [SPAN_W-1:0]          open_cols;
  logic [tsgp_pkg::MAX_COLS-1:0] col_written;

  // Placement in progress.
  logic [SLOT_W-1:0]  p_slot;
  logic [SPAN_W-1:0]  p_rs;
  logic [SPAN_W-1:0]  p_cs;
  logic [CUR_W-1:0]   run_start;
  logic [SPAN_W-1:0]  run_len;
  logic [CUR_W-1:0]   dcol;
  logic               rd_written;
  logic [COL_W-1:0]   wptr;
  logic [SPAN_W-1:0]  wcnt;
  logic [CUR_W-1:0]   res_col;
  logic               res_over;

  logic               place_start;
  logic [CUR_W-1:0]   rd_addr;
  logic [COL_W-1:0]   rd_idx;
  logic [FREE_W-1:0]  ram_q;
  logic [FREE_W-1:0]  free_row;
  logic [FREE_W-1:0]  wdata;
  logic               at_end;
  logic               blocked;
  logic               start_over;
  logic [SPAN_W-1:0]  len_inc;

  assign place_start = cmd.place_empty || cmd.place_open;
  assign rd_addr     = place_start ? cursor : dcol + CUR_W'(1);
  assign rd_idx      = (rd_addr >= CUR_W'(tsgp_pkg::MAX_COLS)) ? '0 : rd_addr[COL_W-1:0];
  assign wdata       = FREE_W'(current_row) + FREE_W'(p_rs);

  tsgp_ram #(
    .WIDTH (FREE_W),
    .DEPTH (tsgp_pkg::MAX_COLS)
  ) u_col_store (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (wptr),
    .wdata (wdata),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  // A column that was never written since the table started is free from row 0.
  assign free_row   = rd_written ? ram_q : '0;
  assign at_end     = dcol >= CUR_W'(tsgp_pkg::MAX_COLS);
  assign blocked    = free_row > FREE_W'(current_row);
  assign start_over = (run_len == '0) &&
                      ((SUM_W'(dcol) + SUM_W'(p_cs)) > SUM_W'(tsgp_pkg::MAX_COLS));
  assign len_inc    = run_len + SPAN_W'(1);

  always_comb begin
    sts.row_seen   = row_seen;
    sts.cell_open  = cell_open;
    sts.empty_ok   = row_seen && (CMP_W'(slot_ctr) < CMP_W'(cell_count)) &&
                     (slot_ctr < SLOT_W'(tsgp_pkg::MAX_CELLS));
    sts.close_ok   = row_seen && (CMP_W'(cell_slot) < CMP_W'(cell_count)) &&
                     (cell_slot < SLOT_W'(tsgp_pkg::MAX_CELLS));
    sts.scan_over  = at_end || (!blocked && start_over);
    sts.scan_found = !at_end && !blocked && !start_over && (len_inc == p_cs);
    sts.write_last = (wcnt == p_cs - SPAN_W'(1));
  end

  // Control state of the table.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      current_row <= '0;
      row_seen    <= 1'b0;
      cursor      <= '0;
      slot_ctr    <= '0;
      cell_open   <= 1'b0;
      cell_slot   <= '0;
      open_rows   <= SPAN_W'(1);
      open_cols   <= SPAN_W'(1);
      col_written <= '0;
    end else begin
      if (cmd.row_start) begin
        if (!row_seen) begin
          row_seen    <= 1'b1;
          current_row <= '0;
        end else if (current_row < ROW_W'(tsgp_pkg::MAX_ROWS - 1)) begin
          current_row <= current_row + ROW_W'(1);
        end
        cursor    <= '0;
        cell_open <= 1'b0;
      end
      if (cmd.take_slot && (slot_ctr < SLOT_W'(tsgp_pkg::MAX_CELLS))) begin
        slot_ctr <= slot_ctr + SLOT_W'(1);
      end
      if (cmd.open_cell) begin
        cell_open <= 1'b1;
        cell_slot <= slot_ctr;
        open_rows <= SPAN_W'(1);
        open_cols <= SPAN_W'(1);
      end
      if (cmd.set_cols) begin
        open_cols <= tsgp_pkg::clamp_span(span_value);
      end
      if (cmd.set_rows) begin
        open_rows <= tsgp_pkg::clamp_span(span_value);
      end
      if (cmd.close_cell) begin
        cell_open <= 1'b0;
      end
      if (cmd.scan && sts.scan_found) begin
        cursor <= CUR_W'(SUM_W'(run_start) + SUM_W'(p_cs));
      end
      if (cmd.write) begin
        col_written[wptr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count <= '0;
    end else if (cfg_we) begin
      cell_count <= cfg_wdata;
    end
  end

  // Run scanner and claim writer.
  always_ff @(posedge clk) begin
    rd_written <= col_written[rd_idx];
    if (place_start) begin
      p_slot    <= cmd.place_empty ? slot_ctr : cell_slot;
      p_rs      <= cmd.place_empty ? SPAN_W'(1) : open_rows;
      p_cs      <= cmd.place_empty ? SPAN_W'(1) : open_cols;
      run_start <= cursor;
      run_len   <= '0;
      dcol      <= cursor;
    end
    if (cmd.scan) begin
      dcol <= dcol + CUR_W'(1);
      if (blocked) begin
        run_start <= dcol + CUR_W'(1);
        run_len   <= '0;
      end else begin
        run_len <= len_inc;
      end
      if (sts.scan_found) begin
        wptr     <= run_start[COL_W-1:0];
        wcnt     <= '0;
        res_col  <= run_start;
        res_over <= 1'b0;
      end else if (sts.scan_over) begin
        res_col  <= '0;
        res_over <= 1'b1;
      end
    end
    if (cmd.write) begin
      wptr <= wptr + COL_W'(1);
      wcnt <= wcnt + SPAN_W'(1);
    end
    if (cmd.load_out) begin
      o_slot   <= tsgp_pkg::SLOT_OUT_W'(p_slot);
      o_row    <= tsgp_pkg::ROW_OUT_W'(current_row);
      o_col    <= tsgp_pkg::COL_OUT_W'(res_col);
      o_rows   <= tsgp_pkg::SPAN_OUT_W'(p_rs);
      o_cols   <= tsgp_pkg::SPAN_OUT_W'(p_cs);
      o_status <= res_over;
    end
  end

endmodule

/* hw/rtl/table_span_grid_placer.sv */
// ----------------------------------------------------------------------------
// table_span_grid_placer
// Token that places nothing: taken while idle. A placed cell is accepted,
// the scan examines one column per cycle over the column store read port,
// the write back claims one spanned column per cycle, and the result is
// loaded once the output register is free; a dropped cell skips the write
// back. Synchronous reset clears table and control state; no clearing sweep.
// ----------------------------------------------------------------------------
module table_span_grid_placer (
  input  logic                       clk,
  input  logic                       rst,
  tsgp_token_if.sink                 token,
  tsgp_place_if.source               placement,
  input  logic                       cfg_we,
  input  logic [tsgp_pkg::CFG_W-1:0] cfg_wdata
);

  // The controller decodes each token word and sequences a placement through
  // scan, write back and load. The datapath owns every piece of table state.
  tsgp_pkg::tsgp_cmd_t cmd;
  tsgp_pkg::tsgp_sts_t sts;
  logic                out_valid;

  tsgp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token.valid),
    .op          (token.op),
    .token_ready (token.ready),
    .out_ready   (placement.ready),
    .out_valid   (out_valid),
    .sts         (sts),
    .cmd         (cmd)
  );

  // The column store keeps, per column, the first row at which that column is
  // free again. Columns never written since the table started read as free
  // from row zero through a per-column flag that start table clears at once.
  tsgp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .span_value (token.span_value),
    .cmd        (cmd),
    .sts        (sts),
    .o_slot     (placement.slot),
    .o_row      (placement.row),
    .o_col      (placement.col),
    .o_rows     (placement.rows_spanned),
    .o_cols     (placement.cols_spanned),
    .o_status   (placement.status)
  );

  // The placement word sits in an output register, so non-placing tokens keep
  // flowing while a result waits to be taken.
  assign placement.valid = out_valid;

  // A result is only loaded when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!placement.valid || placement.ready))
    else $error("placement loaded over a pending word");

  // Once a placement starts, no token is taken until it completes.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.place_empty || cmd.place_open) |=> !token.ready)
    else $error("token accepted during placement");

  // A found run is claimed in the very next cycle.
  a_found_writes: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && sts.scan_found) |=> cmd.write)
    else $error("found run not written back");

  // A loaded result is presented on the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> placement.valid)
    else $error("loaded placement not presented");

endmodule
